@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bhfl_pkg.sv @@
// Shared constants, types and saturation helpers for the byte histogram.
// No dependencies.
package bhfl_pkg;

    localparam int LOCATIONS_KEPT = 3;
    localparam int COUNT_BITS     = 32;
    localparam int POSITION_BITS  = 32;

    localparam int NUM_BINS   = 256;
    localparam int BIN_BITS   = $clog2(NUM_BINS);
    localparam int OUT_LOCS   = 3;
    localparam int FIELD_BITS = 32;
    localparam int NVALID_BITS = 2;
    localparam int KEPT_CAP   = (LOCATIONS_KEPT < OUT_LOCS) ? LOCATIONS_KEPT : OUT_LOCS;

    localparam int COUNT_EXT_BITS = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
    localparam int POS_EXT_BITS   = (POSITION_BITS > FIELD_BITS) ? POSITION_BITS : FIELD_BITS;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_COUNT = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_FINISH = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;  // latch the request and read the count and location memories
        logic commit;   // update state and load the result register
    } cmd_t;

    function automatic logic [FIELD_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_EXT_BITS-1:0] ext;
        ext = COUNT_EXT_BITS'(c);
        if (ext > COUNT_EXT_BITS'({FIELD_BITS{1'b1}}))
            return {FIELD_BITS{1'b1}};
        return ext[FIELD_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] sat_position(
        input logic [POSITION_BITS-1:0] p);
        logic [POS_EXT_BITS-1:0] ext;
        ext = POS_EXT_BITS'(p);
        if (ext > POS_EXT_BITS'({FIELD_BITS{1'b1}}))
            return {FIELD_BITS{1'b1}};
        return ext[FIELD_BITS-1:0];
    endfunction

endpackage

@@ hdl/bhfl_ctrl.sv @@
// Controller: sequences one request at a time and owns the result valid flag.
// Depends on bhfl_pkg.
module bhfl_ctrl import bhfl_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_FINISH:
            begin
                cmd.commit = !out_valid_reg || out_ready;
            end
            default: ;
        endcase
        out_valid_next = cmd.commit ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hdl/bhfl_datapath.sv @@
// Datapath: count and location memories, bin valid bits, stream position, result register.
// Depends on bhfl_pkg.
module bhfl_datapath import bhfl_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [1:0]            operation,
    input  logic [BIN_BITS-1:0]   byte_value,
    input  logic [BIN_BITS-1:0]   read_bin,
    output logic [FIELD_BITS-1:0] bin_count,
    output logic [FIELD_BITS-1:0] first_location,
    output logic [FIELD_BITS-1:0] second_location,
    output logic [FIELD_BITS-1:0] third_location,
    output logic [NVALID_BITS-1:0] valid_locations,
    output logic                  more_than_kept
);

    logic [1:0]               op_reg;
    logic [BIN_BITS-1:0]      bin_reg;
    logic [BIN_BITS-1:0]      bin_sel;
    logic [NUM_BINS-1:0]      bin_valid_reg;
    logic [POSITION_BITS-1:0] position_reg;

    logic [COUNT_BITS-1:0]    count_mem [NUM_BINS];
    logic [COUNT_BITS-1:0]    count_rd_reg;
    logic [POSITION_BITS-1:0] loc_rd_reg [LOCATIONS_KEPT];

    logic [COUNT_BITS-1:0]    cnt_cur;
    logic [COUNT_BITS-1:0]    cnt_inc;
    logic                     do_count;
    logic                     do_clear;
    logic                     do_read;
    logic [NVALID_BITS-1:0]   nvalid;
    logic [FIELD_BITS-1:0]    loc_field [OUT_LOCS];

    logic [FIELD_BITS-1:0]    bin_count_reg;
    logic [FIELD_BITS-1:0]    loc_out_reg [OUT_LOCS];
    logic [NVALID_BITS-1:0]   valid_locations_reg;
    logic                     more_than_kept_reg;

    assign bin_sel  = (operation == OP_READ) ? read_bin : byte_value;
    assign do_count = cmd.commit && (op_reg == OP_COUNT);
    assign do_clear = cmd.commit && (op_reg == OP_CLEAR);
    assign do_read  = (op_reg == OP_READ);

    // A bin that was never counted since the last clear reads as zero.
    assign cnt_cur = bin_valid_reg[bin_reg] ? count_rd_reg : '0;
    assign cnt_inc = (cnt_cur == {COUNT_BITS{1'b1}}) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
    assign nvalid  = (cnt_cur < COUNT_BITS'(KEPT_CAP)) ? cnt_cur[NVALID_BITS-1:0]
                                                       : NVALID_BITS'(KEPT_CAP);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= operation;
            bin_reg      <= bin_sel;
            count_rd_reg <= count_mem[bin_sel];
        end
        if (do_count)
            count_mem[bin_reg] <= cnt_inc;
    end

    // One location memory per kept slot; slot k takes the position on the hit that finds k earlier hits.
    genvar k;
    generate
        for (k = 0; k < LOCATIONS_KEPT; k++)
        begin : g_lane
            logic [POSITION_BITS-1:0] loc_mem [NUM_BINS];

            always_ff @(posedge clk)
            begin
                if (cmd.capture)
                    loc_rd_reg[k] <= loc_mem[bin_sel];
                if (do_count && (cnt_cur == COUNT_BITS'(k)))
                    loc_mem[bin_reg] <= position_reg;
            end
        end
    endgenerate

    genvar j;
    generate
        for (j = 0; j < OUT_LOCS; j++)
        begin : g_field
            if (j < LOCATIONS_KEPT)
            begin : g_kept
                assign loc_field[j] = (nvalid > NVALID_BITS'(j))
                                    ? sat_position(loc_rd_reg[j]) : '0;
            end
            else
            begin : g_none
                assign loc_field[j] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            position_reg  <= '0;
        end
        else if (do_clear)
        begin
            bin_valid_reg <= '0;
            position_reg  <= '0;
        end
        else if (do_count)
        begin
            bin_valid_reg[bin_reg] <= 1'b1;
            if (position_reg != {POSITION_BITS{1'b1}})
                position_reg <= position_reg + POSITION_BITS'(1);
        end
    end

    // Result register: clear, count and unused codes report all zeros.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            bin_count_reg       <= do_read ? sat_count(cnt_cur) : '0;
            valid_locations_reg <= do_read ? nvalid : '0;
            more_than_kept_reg  <= do_read && (cnt_cur > COUNT_BITS'(LOCATIONS_KEPT));
            for (int i = 0; i < OUT_LOCS; i++)
                loc_out_reg[i] <= do_read ? loc_field[i] : '0;
        end
    end

    assign bin_count       = bin_count_reg;
    assign first_location  = loc_out_reg[0];
    assign second_location = loc_out_reg[1];
    assign third_location  = loc_out_reg[2];
    assign valid_locations = valid_locations_reg;
    assign more_than_kept  = more_than_kept_reg;

endmodule

@@ hdl/byte_histogram_with_first_locations.sv @@
// Byte histogram with first-occurrence locations: 256 saturating bins, 3 kept positions each.
// A request is captured and the bin memories are read into registers at accept; the
// read-modify-write commit then updates the bins and loads the result register. A new request
// is taken only after the previous one commits; the commit is held while a result waits on out_ready.
// Reset (async, active low): all bins empty via valid bits, stream position zero, no result.
// Location memories are not cleared; only slots written since a bin's last clear are shown.
module byte_histogram_with_first_locations import bhfl_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             operation,
    input  logic [BIN_BITS-1:0]    byte_value,
    input  logic [BIN_BITS-1:0]    read_bin,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [FIELD_BITS-1:0]  bin_count,
    output logic [FIELD_BITS-1:0]  first_location,
    output logic [FIELD_BITS-1:0]  second_location,
    output logic [FIELD_BITS-1:0]  third_location,
    output logic [NVALID_BITS-1:0] valid_locations,
    output logic                   more_than_kept
);

    // Commands from the controller: capture on request accept, commit when
    // the result register is free (empty or being drained this cycle).
    cmd_t cmd;

    bhfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Datapath holds the memories and the result register; every request,
    // including clear and count, produces exactly one result.
    bhfl_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .operation       (operation),
        .byte_value      (byte_value),
        .read_bin        (read_bin),
        .bin_count       (bin_count),
        .first_location  (first_location),
        .second_location (second_location),
        .third_location  (third_location),
        .valid_locations (valid_locations),
        .more_than_kept  (more_than_kept)
    );

endmodule

@@ hdl/bhfl_checker.sv @@
// Port-level checker for the byte histogram, bound to the top level.
// Depends on bhfl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bhfl_checker import bhfl_pkg::*; (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic [1:0]             operation,
    input logic [BIN_BITS-1:0]    byte_value,
    input logic [BIN_BITS-1:0]    read_bin,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [FIELD_BITS-1:0]  bin_count,
    input logic [FIELD_BITS-1:0]  first_location,
    input logic [FIELD_BITS-1:0]  second_location,
    input logic [FIELD_BITS-1:0]  third_location,
    input logic [NVALID_BITS-1:0] valid_locations,
    input logic                   more_than_kept
);

    `ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid && $stable(bin_count) && $stable(valid_locations), "stalled result changed")
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "request accepted while one is in flight")
    `ASSERT_IMPLIES(a_overflow_full, clk, rst_n, out_valid && more_than_kept, valid_locations == NVALID_BITS'(KEPT_CAP), "overflowing bin shows fewer than all kept locations")
    `ASSERT_IMPLIES(a_empty_zero, clk, rst_n, out_valid && (valid_locations == '0), (first_location == '0) && (second_location == '0) && (third_location == '0), "location shown for an empty slot")
    `ASSERT_IMPLIES(a_zero_count, clk, rst_n, out_valid && (bin_count == '0), (valid_locations == '0) && !more_than_kept, "empty bin reports locations")

endmodule

bind byte_histogram_with_first_locations bhfl_checker u_checker (.*);

@@ dv/tb.sv @@
// Self-checking bench for byte_histogram_with_first_locations: random and directed requests.
// Keeps its own copy of the bins, locations and stream position; depends on hdl/bhfl_pkg.sv.
`timescale 1ns / 100ps

module tb;
    import bhfl_pkg::*;

    // Code the block treats as a no-op; the package enum stops at the read.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Give up long after the slowest legal run would have finished.
    localparam int CYCLE_LIMIT = 200000;

    // Cycles to keep watching the output after the last result.
    localparam int TAIL_CYCLES = 16;

    // One request as queued for the driver, with the idling profile it is sent under.
    typedef struct packed {
        logic [1:0]          op;
        logic [BIN_BITS-1:0] data;
        logic [BIN_BITS-1:0] bin;
        logic                drain_first;  // hold off until every result is back
        logic [6:0]          gap_pct;      // sender idle chance per cycle
        logic [6:0]          stall_pct;    // receiver stall chance per cycle
    } request_t;

    // One expected result, field for field as the ports carry it.
    typedef struct packed {
        logic [FIELD_BITS-1:0]  bin_count;
        logic [FIELD_BITS-1:0]  first_location;
        logic [FIELD_BITS-1:0]  second_location;
        logic [FIELD_BITS-1:0]  third_location;
        logic [NVALID_BITS-1:0] valid_locations;
        logic                   more_than_kept;
    } bin_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             operation = OP_CLEAR;
    logic [BIN_BITS-1:0]    byte_value = '0;
    logic [BIN_BITS-1:0]    read_bin = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [FIELD_BITS-1:0]  bin_count;
    logic [FIELD_BITS-1:0]  first_location;
    logic [FIELD_BITS-1:0]  second_location;
    logic [FIELD_BITS-1:0]  third_location;
    logic [NVALID_BITS-1:0] valid_locations;
    logic                   more_than_kept;

    // Requests still to be sent and results still owed by the block.
    request_t    pending_reqs[$];
    bin_report_t expected_reports[$];

    logic        req_taken = 1'b0;   // request on the bus was accepted at the last edge
    logic [6:0]  stall_pct = '0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // Profile stamped on requests as the stimulus is built.
    logic        drain_next = 1'b0;
    logic [6:0]  gap_now = '0;
    logic [6:0]  stall_now = '0;

    // Shadow histogram: counts, valid bits, kept positions and the running position.
    logic [COUNT_BITS-1:0]    tally [NUM_BINS];
    logic [NUM_BINS-1:0]      bin_used = '0;
    logic [POSITION_BITS-1:0] seen_at [NUM_BINS][LOCATIONS_KEPT];
    logic [POSITION_BITS-1:0] stream_pos = '0;

    byte_histogram_with_first_locations i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .byte_value      (byte_value),
        .read_bin        (read_bin),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bin_count       (bin_count),
        .first_location  (first_location),
        .second_location (second_location),
        .third_location  (third_location),
        .valid_locations (valid_locations),
        .more_than_kept  (more_than_kept)
    );

    always #4 clk = ~clk;

    // Apply one accepted request to the shadow histogram and return the result it owes.
    function automatic bin_report_t histogram_step(
        input logic [1:0]          op,
        input logic [BIN_BITS-1:0] data,
        input logic [BIN_BITS-1:0] bin
    );
        bin_report_t           rep;
        logic [COUNT_BITS-1:0] cnt;
        int                    kept;
        rep = '0;
        case (op)
            OP_CLEAR:
            begin
                // Drop every valid bit; stored positions stay but become unreachable.
                bin_used   = '0;
                stream_pos = '0;
            end
            OP_COUNT:
            begin
                cnt = bin_used[data] ? tally[data] : '0;
                if (cnt < LOCATIONS_KEPT)
                    seen_at[data][int'(cnt)] = stream_pos;
                if (cnt != '1)
                    cnt = cnt + 1'b1;
                tally[data]    = cnt;
                bin_used[data] = 1'b1;
                if (stream_pos != '1)
                    stream_pos = stream_pos + 1'b1;
            end
            OP_READ:
            begin
                cnt  = bin_used[bin] ? tally[bin] : '0;
                kept = (cnt < KEPT_CAP) ? int'(cnt) : KEPT_CAP;
                rep.bin_count = FIELD_BITS'(cnt);
                // Show only positions written since the bin was last emptied.
                if (kept >= 1)
                    rep.first_location = FIELD_BITS'(seen_at[bin][0]);
                if (kept >= 2)
                    rep.second_location = FIELD_BITS'(seen_at[bin][1]);
                if (kept >= 3)
                    rep.third_location = FIELD_BITS'(seen_at[bin][2]);
                rep.valid_locations = NVALID_BITS'(kept);
                rep.more_than_kept  = (cnt > LOCATIONS_KEPT);
            end
            default:
            begin
                // Unused code: no state change, all-zero result.
            end
        endcase
        return rep;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(
        input string           name,
        input logic [FIELD_BITS-1:0] got,
        input logic [FIELD_BITS-1:0] want
    );
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task automatic queue_request(
        input logic [1:0]          op,
        input logic [BIN_BITS-1:0] data,
        input logic [BIN_BITS-1:0] bin
    );
        request_t req;
        req.op          = op;
        req.data        = data;
        req.bin         = bin;
        req.drain_first = drain_next;
        req.gap_pct     = gap_now;
        req.stall_pct   = stall_now;
        drain_next      = 1'b0;
        pending_reqs.push_back(req);
    endtask

    // Driver: hold an unaccepted request, otherwise idle or advance to the next one.
    always @(negedge clk) begin : drive_requests
        request_t req;
        logic     holding;
        logic     send;
        holding = in_valid && !req_taken;
        send    = holding;
        if (rst_n && !holding && pending_reqs.size() != 0) begin
            // Drain point: hold back until the block has returned every result.
            if (!(pending_reqs[0].drain_first && expected_reports.size() != 0)
                && $urandom_range(99) >= pending_reqs[0].gap_pct) begin
                req        = pending_reqs.pop_front();
                send       = 1'b1;
                operation  <= req.op;
                byte_value <= req.data;
                read_bin   <= req.bin;
                stall_pct  <= req.stall_pct;
            end
        end
        in_valid <= send;
    end

    // Receiver: stall at the rate of the current phase.
    always @(negedge clk) begin
        out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    // Monitor: check each delivered result against the oldest expectation,
    // then predict the result of any request accepted at this edge.
    always @(posedge clk) begin : score_results
        bin_report_t want;
        req_taken <= rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end
            else begin
                want = expected_reports.pop_front();
                check_field("bin_count", bin_count, want.bin_count);
                check_field("first_location", first_location, want.first_location);
                check_field("second_location", second_location, want.second_location);
                check_field("third_location", third_location, want.third_location);
                check_field("valid_locations", FIELD_BITS'(valid_locations),
                            FIELD_BITS'(want.valid_locations));
                check_field("more_than_kept", FIELD_BITS'(more_than_kept),
                            FIELD_BITS'(want.more_than_kept));
            end
        end
        if (rst_n && in_valid && in_ready)
            expected_reports.push_back(histogram_step(operation, byte_value, read_bin));
    end

    // Watchdog on total run length.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d results outstanding", $time,
                     expected_reports.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : run_test
        int                  pick;
        logic [BIN_BITS-1:0] hot_base;
        logic [BIN_BITS-1:0] data;
        logic [BIN_BITS-1:0] bin;

        // Directed: empty bins, the unused code, edge byte values, more hits than
        // kept locations, clear with the position restarting from zero.
        queue_request(OP_READ, 8'h00, 8'h00);
        queue_request(OP_READ, 8'hff, 8'hff);
        queue_request(OP_UNUSED, 8'hff, 8'hff);
        queue_request(OP_COUNT, 8'h00, 8'hff);
        queue_request(OP_COUNT, 8'hff, 8'h00);
        queue_request(OP_COUNT, 8'hff, 8'h00);
        queue_request(OP_COUNT, 8'hff, 8'h00);
        queue_request(OP_COUNT, 8'hff, 8'h00);
        queue_request(OP_READ, 8'h00, 8'hff);
        queue_request(OP_READ, 8'hff, 8'h00);
        queue_request(OP_COUNT, 8'h55, 8'haa);
        queue_request(OP_COUNT, 8'haa, 8'h55);
        queue_request(OP_COUNT, 8'h55, 8'haa);
        queue_request(OP_READ, 8'haa, 8'h55);
        queue_request(OP_READ, 8'h55, 8'haa);
        queue_request(OP_CLEAR, 8'hff, 8'hff);
        queue_request(OP_READ, 8'h00, 8'hff);
        queue_request(OP_COUNT, 8'hff, 8'h00);
        queue_request(OP_READ, 8'h00, 8'hff);
        queue_request(OP_UNUSED, 8'h00, 8'h00);
        queue_request(OP_COUNT, 8'h00, 8'h00);
        queue_request(OP_READ, 8'hff, 8'h00);

        // Random: counts and reads mostly aimed at a small hot set of bins so that
        // bins fill past the kept locations; clears move the hot set.
        hot_base = 8'($urandom_range(255));
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin gap_now = 7'd0;  stall_now = 7'd0;  end
                1:       begin gap_now = 7'd74; stall_now = 7'd0;  end
                2:       begin gap_now = 7'd0;  stall_now = 7'd74; end
                default: begin gap_now = 7'd8;  stall_now = 7'd8;  end
            endcase
            drain_next = 1'b1;
            for (int n = 0; n < 225; n++) begin
                pick = $urandom_range(99);
                data = ($urandom_range(99) < 60) ? hot_base ^ 8'($urandom_range(3))
                                                 : 8'($urandom_range(255));
                bin  = ($urandom_range(99) < 60) ? hot_base ^ 8'($urandom_range(3))
                                                 : 8'($urandom_range(255));
                if ($urandom_range(99) == 0)
                    drain_next = 1'b1;
                if (pick < 1) begin
                    queue_request(OP_CLEAR, data, bin);
                    hot_base = 8'($urandom_range(255));
                end
                else if (pick < 2)
                    queue_request(OP_UNUSED, data, bin);
                else if (pick < 57)
                    queue_request(OP_COUNT, data, bin);
                else
                    queue_request(OP_READ, data, bin);
            end
        end

        // Hold reset, then release it away from the active edge.
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every request is sent and every result is back.
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_reports.size() != 0);

        // Watch a little longer for stray results.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
